### design/srfd_pkg.sv
// shared types, codes and constants of the serial frame deframer
package srfd_pkg;

  // largest payload length the design ever takes, whatever max_payload says
  localparam int unsigned PayloadLimit = 64;

  // configuration register indexes
  localparam logic [1:0] REG_START_MARKER = 2'd0;
  localparam logic [1:0] REG_END_MARKER   = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd2;
  localparam logic [1:0] REG_CRC_TAPS     = 2'd3;

  // reset values of the configuration registers
  localparam logic [7:0]  START_MARKER_RST = 8'hAA;
  localparam logic [7:0]  END_MARKER_RST   = 8'h55;
  localparam logic [6:0]  MAX_PAYLOAD_RST  = 7'd64;
  localparam logic [15:0] CRC_TAPS_RST     = 16'hA001;

  // crc seed at the start of each frame
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // result kinds
  localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
  localparam logic [2:0] KIND_GOOD     = 3'd1;
  localparam logic [2:0] KIND_CRC_ERR  = 3'd2;
  localparam logic [2:0] KIND_END_ERR  = 3'd3;
  localparam logic [2:0] KIND_LEN_ERR  = 3'd4;

  // input beat types
  localparam logic REQ_BYTE     = 1'b0;
  localparam logic REQ_LINE_ERR = 1'b1;

  // configuration as seen by the parser
  typedef struct packed {
    logic [7:0]  start_marker;
    logic [7:0]  end_marker;
    logic [6:0]  max_payload;
    logic [15:0] crc_taps;
  } cfg_t;

  // one result beat
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  frame_cmd;
    logic [7:0]  payload_byte;
    logic [5:0]  byte_index;
    logic [7:0]  frame_length;
    logic [15:0] crc_received;
    logic [15:0] crc_computed;
  } result_t;

endpackage

### design/srfd_cfg.sv
// configuration registers of the serial frame deframer
module srfd_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output srfd_pkg::cfg_t      cfg_o
);

  srfd_pkg::cfg_t cfg_q, cfg_d;

  // decode of the register index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        srfd_pkg::REG_START_MARKER: cfg_d.start_marker = cfg_data_i[7:0];
        srfd_pkg::REG_END_MARKER:   cfg_d.end_marker   = cfg_data_i[7:0];
        srfd_pkg::REG_MAX_PAYLOAD:  cfg_d.max_payload  = cfg_data_i[6:0];
        srfd_pkg::REG_CRC_TAPS:     cfg_d.crc_taps     = cfg_data_i;
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  // register bank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker <= srfd_pkg::START_MARKER_RST;
      cfg_q.end_marker   <= srfd_pkg::END_MARKER_RST;
      cfg_q.max_payload  <= srfd_pkg::MAX_PAYLOAD_RST;
      cfg_q.crc_taps     <= srfd_pkg::CRC_TAPS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/srfd_crc.sv
// reflected crc-16 update over one byte, eight bit steps unrolled
module srfd_crc (
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  input  logic [15:0] poly_i,
  output logic [15:0] crc_o
);

  logic [15:0] acc;

  // right-shift update, lsb first
  always_comb begin
    acc = crc_i ^ {8'h00, data_i};
    for (int b = 0; b < 8; b++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ poly_i;
      end else begin
        acc = acc >> 1;
      end
    end
    crc_o = acc;
  end

endmodule

### design/srfd_parse.sv
// frame parser state machine and result register
module srfd_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 adv_i,
  input  logic                 req_i,
  input  logic [7:0]           byte_i,
  input  srfd_pkg::cfg_t       cfg_i,
  output logic                 res_valid_o,
  output srfd_pkg::result_t    res_o
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_CMD  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CRCH = 3'd4;
  localparam logic [2:0] PH_CRCL = 3'd5;
  localparam logic [2:0] PH_END  = 3'd6;

  localparam logic [7:0] LIMIT_CAP = 8'(srfd_pkg::PayloadLimit);

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [6:0]  count_q, count_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] held_crc_q, held_crc_d;

  logic              res_valid_q, res_valid_d;
  srfd_pkg::result_t res_q, res_d;

  logic              emit;
  srfd_pkg::result_t emit_res;
  logic [15:0]       crc_next;
  logic [7:0]        limit;
  logic [6:0]        count_inc;

  srfd_crc u_crc (
    .crc_i  (crc_q),
    .data_i (byte_i),
    .poly_i (cfg_i.crc_taps),
    .crc_o  (crc_next)
  );

  // effective length limit
  always_comb begin
    if ({1'b0, cfg_i.max_payload} > LIMIT_CAP) begin
      limit = LIMIT_CAP;
    end else begin
      limit = {1'b0, cfg_i.max_payload};
    end
  end

  assign count_inc = count_q + 7'd1;

  // next state and result of one beat
  always_comb begin
    phase_d    = phase_q;
    len_d      = len_q;
    cmd_d      = cmd_q;
    count_d    = count_q;
    crc_d      = crc_q;
    held_crc_d = held_crc_q;
    emit       = 1'b0;
    emit_res   = '0;

    if (req_i == srfd_pkg::REQ_LINE_ERR) begin
      phase_d = PH_IDLE;
    end else begin
      unique case (phase_q)
        PH_LEN: begin
          len_d = byte_i;
          if (byte_i <= limit) begin
            count_d = '0;
            crc_d   = srfd_pkg::CRC_INIT;
            phase_d = PH_CMD;
          end else begin
            phase_d               = PH_IDLE;
            emit                  = 1'b1;
            emit_res.kind         = srfd_pkg::KIND_LEN_ERR;
            emit_res.frame_length = byte_i;
          end
        end
        PH_CMD: begin
          cmd_d   = byte_i;
          crc_d   = crc_next;
          phase_d = (len_q != 8'd0) ? PH_DATA : PH_CRCH;
        end
        PH_DATA: begin
          crc_d   = crc_next;
          count_d = count_inc;
          if ({1'b0, count_inc} >= len_q) begin
            phase_d = PH_CRCH;
          end
          emit                  = 1'b1;
          emit_res.kind         = srfd_pkg::KIND_PAYLOAD;
          emit_res.frame_cmd    = cmd_q;
          emit_res.payload_byte = byte_i;
          emit_res.byte_index   = count_q[5:0];
          emit_res.frame_length = len_q;
        end
        PH_CRCH: begin
          held_crc_d = {byte_i, 8'h00};
          phase_d    = PH_CRCL;
        end
        PH_CRCL: begin
          held_crc_d = {held_crc_q[15:8], byte_i};
          phase_d    = PH_END;
        end
        PH_END: begin
          phase_d = PH_IDLE;
          emit    = 1'b1;
          if (byte_i != cfg_i.end_marker) begin
            emit_res.kind = srfd_pkg::KIND_END_ERR;
          end else if (crc_q == held_crc_q) begin
            emit_res.kind = srfd_pkg::KIND_GOOD;
          end else begin
            emit_res.kind = srfd_pkg::KIND_CRC_ERR;
          end
          emit_res.frame_cmd    = cmd_q;
          emit_res.frame_length = len_q;
          emit_res.crc_received = held_crc_q;
          emit_res.crc_computed = crc_q;
        end
        default: begin
          // idle and unused codes hunt for the start marker
          phase_d = (byte_i == cfg_i.start_marker) ? PH_LEN : PH_IDLE;
        end
      endcase
    end
  end

  // result register loads whenever the output side is free
  always_comb begin
    res_valid_d = res_valid_q;
    res_d       = res_q;
    if (adv_i) begin
      res_valid_d = step_i && emit;
      res_d       = emit_res;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      len_q      <= '0;
      cmd_q      <= '0;
      count_q    <= '0;
      crc_q      <= srfd_pkg::CRC_INIT;
      held_crc_q <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      len_q      <= len_d;
      cmd_q      <= cmd_d;
      count_q    <= count_d;
      crc_q      <= crc_d;
      held_crc_q <= held_crc_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### design/serial_frame_rx_deframer.sv
// Serial frame deframer top level. Received UART bytes and line-error events enter as beats
// on the input channel; payload bytes and frame status beats leave on the output channel.
// One input beat is taken every clock cycle when the output side keeps up. A beat is held
// in an input register and parsed with a one-byte CRC-16 update once the result register
// is free; its result, if any, is then registered. The single-byte CRC update between the
// input and result registers sets the cycle time. The user makes configuration writes
// only while no frame is in flight; the block itself does not enforce this.
module serial_frame_rx_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  rx_byte_i,
  // result beats
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  frame_cmd_o,
  output logic [7:0]  payload_byte_o,
  output logic [5:0]  byte_index_o,
  output logic [7:0]  frame_length_o,
  output logic [15:0] crc_received_o,
  output logic [15:0] crc_computed_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  srfd_pkg::cfg_t    cfg;
  srfd_pkg::result_t res;

  logic       in_valid_q, in_valid_d;
  logic       in_req_q;
  logic [7:0] in_byte_q;
  logic       res_valid;
  logic       adv;
  logic       step;

  // the result register is free when empty or being taken
  assign adv         = !res_valid || out_ready_i;
  assign step        = in_valid_q && adv;
  assign in_ready_o  = !in_valid_q || adv;
  assign cfg_ready_o = 1'b1;

  // input register valid
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_req_q  <= req_type_i;
      in_byte_q <= rx_byte_i;
    end
  end

  srfd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  srfd_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .adv_i       (adv),
    .req_i       (in_req_q),
    .byte_i      (in_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result ports
  assign out_valid_o    = res_valid;
  assign kind_o         = res.kind;
  assign frame_cmd_o    = res.frame_cmd;
  assign payload_byte_o = res.payload_byte;
  assign byte_index_o   = res.byte_index;
  assign frame_length_o = res.frame_length;
  assign crc_received_o = res.crc_received;
  assign crc_computed_o = res.crc_computed;

endmodule

### design/srfd_checker.sv
// port-level checks of the serial frame deframer, bound to the top level
module srfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  kind_o,
  input logic [7:0]  frame_cmd_o,
  input logic [7:0]  payload_byte_o,
  input logic [5:0]  byte_index_o,
  input logic [7:0]  frame_length_o,
  input logic [15:0] crc_received_o,
  input logic [15:0] crc_computed_o
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // a good frame carries matching crc values
  a_good_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == srfd_pkg::KIND_GOOD) |-> crc_received_o == crc_computed_o)
    else $error("frame good reported with differing crc");

  // a length error carries no frame content and a nonzero length
  a_len_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == srfd_pkg::KIND_LEN_ERR) |->
      (frame_cmd_o == 8'd0) && (payload_byte_o == 8'd0) && (crc_computed_o == 16'd0)
      && (crc_received_o == 16'd0) && (frame_length_o != 8'd0))
    else $error("length error beat carries frame content");

  // a payload beat lies inside the frame length and carries no received crc
  a_pay_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == srfd_pkg::KIND_PAYLOAD) |->
      ({2'b00, byte_index_o} < frame_length_o) && (crc_received_o == 16'd0))
    else $error("payload index beyond frame length");

endmodule

bind serial_frame_rx_deframer srfd_checker u_srfd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .kind_o         (kind_o),
  .frame_cmd_o    (frame_cmd_o),
  .payload_byte_o (payload_byte_o),
  .byte_index_o   (byte_index_o),
  .frame_length_o (frame_length_o),
  .crc_received_o (crc_received_o),
  .crc_computed_o (crc_computed_o)
);
